### hdl/lzwvd_pkg.sv
// lzwvd_pkg: shared constants and types for the variable-width lzw decoder
// used by the decoder, its unpacker, checker and testbench; no dependencies
package lzwvd_pkg;

  localparam int DICT_ENTRIES_DEF = 2048;
  localparam int WIDTH_STOP_DEF   = 12;
  localparam int STACK_DEPTH_DEF  = 2048;
  localparam int WIDTH_START      = 9;

  localparam logic [8:0]  CODE_RESTART = 9'h100;
  localparam logic [8:0]  CODE_END     = 9'h101;
  localparam logic [8:0]  FREE_INIT    = 9'd257;
  localparam logic [8:0]  FREE_RESTART = 9'd258;
  localparam logic [23:0] COUNT_MAX    = 24'hFFFFFF;
  localparam int          CHUNK_BYTES  = 32;

  typedef enum logic [1:0] {
    PH_SEED, PH_RUN, PH_AFTER_RESTART, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_WAIT, S_ACCT, S_EMIT, S_DRAIN, S_PUSH, S_MARK
  } state_t;

endpackage

### hdl/lzw_variable_width_decoder.sv
// lzw_variable_width_decoder: top level, dictionary and string stack memories,
// chain walk sequencer and 32-byte chunk output; depends on lzwvd_pkg, lzwvd_unpack
//
//   channel | signals                                   | direction
//   input   | in_valid, in_stall, start_stream, data_byte | item in
//   output  | out_valid, out_stall, chunk_word_0..3,      | item out
//           | valid_bytes, last_chunk, stream_done        |
//   config  | cfg_we, cfg_wdata (output_limit)            | write only
//
// an item that completes no code is taken while idle; a code is taken, then each
// chain link is a dictionary read then a stack push, then come the last push and
// the byte count, then each chunk is read from the stack byte by byte and pushed;
// output stalls hold the push. sync reset clears control state; memories hold
// garbage until written. a waiting output item does not block the input: the
// last chunk is parked in the output register and the sequencer returns to idle.
module lzw_variable_width_decoder
  import lzwvd_pkg::*;
#(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
  parameter int WIDTH_STOP   = WIDTH_STOP_DEF,
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_stream,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] chunk_word_0,
  output logic [63:0] chunk_word_1,
  output logic [63:0] chunk_word_2,
  output logic [63:0] chunk_word_3,
  output logic [5:0]  valid_bytes,
  output logic        last_chunk,
  output logic        stream_done,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  localparam int CODE_W     = WIDTH_STOP - 1;
  localparam int CW_W       = $clog2(WIDTH_STOP);
  localparam int DI_W       = $clog2(DICT_ENTRIES);
  localparam int SI_W       = $clog2(STACK_DEPTH);
  localparam int STRING_CAP = (STACK_DEPTH < 2048) ? STACK_DEPTH : 2048;
  localparam int LEN_W      = $clog2(STRING_CAP + 1);
  localparam int NFC_W      = ((DI_W >= CODE_W) ? DI_W : CODE_W) + 1;

  // control and stream state
  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [CW_W-1:0]   cw, cw_next;
  logic [NFC_W-1:0]  nfc, nfc_next;
  logic [CODE_W-1:0] prev, prev_next;
  logic [7:0]        lfb, lfb_next;
  logic [23:0]       emitted, emitted_next;
  logic [23:0]       limit;

  // per-code work registers
  logic [CODE_W-1:0] cur, cur_next;
  logic [CODE_W-1:0] code_in, code_in_next;
  logic [LEN_W-1:0]  depth, depth_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [7:0]        first, first_next;
  logic              restart_emit, restart_emit_next;
  logic              done_r, done_r_next;
  logic              oob, oob_next;
  logic [LEN_W-1:0]  pos, pos_next;
  logic [5:0]        nchunk, nchunk_next;
  logic [5:0]        iss, iss_next;
  logic [LEN_W-1:0]  rd_addr, rd_addr_next;
  logic              rd_v, rd_v_next;
  logic [4:0]        rd_idx, rd_idx_next;
  logic              chunk_clear;
  logic [255:0]      chunk;

  // output register
  logic         out_load, out_marker;
  logic [255:0] out_chunk;
  logic [5:0]   out_vb_next;
  logic         out_last_next, out_done_next;

  // memories
  logic [CODE_W-1:0] pfx_mem [DICT_ENTRIES];
  logic [7:0]        sfx_mem [DICT_ENTRIES];
  logic [7:0]        stk_mem [STACK_DEPTH];
  logic              dict_re, dict_we, stk_we, stk_re;
  logic [DI_W-1:0]   dict_raddr, dict_waddr;
  logic [CODE_W-1:0] pfx_q;
  logic [7:0]        sfx_q, stk_q, stk_wdata;
  logic [SI_W-1:0]   stk_waddr;

  // unpacker hookup
  logic              fire, start_eff, shift_en, code_valid;
  logic [CODE_W-1:0] code;
  phase_t            ph_e;
  logic [CW_W-1:0]   cw_e;

  // helpers
  logic [NFC_W-1:0] grow_lim;
  logic [24:0]      sum;
  logic [LEN_W-1:0] rem, pos_adv;

  assign in_stall  = (state != S_IDLE);
  assign fire      = in_valid && !in_stall;
  assign start_eff = fire && start_stream;
  assign ph_e      = start_stream ? PH_SEED : phase;
  assign cw_e      = start_stream ? CW_W'(WIDTH_START) : cw;
  assign shift_en  = fire && (ph_e != PH_DONE);

  lzwvd_unpack #(.CODE_W(CODE_W), .CW_W(CW_W)) u_unpack (
    .clk        (clk),
    .rst        (rst),
    .clear      (start_eff),
    .shift_en   (shift_en),
    .data_byte  (data_byte),
    .code_width (cw_e),
    .code_valid (code_valid),
    .code       (code)
  );

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    cw_next           = cw;
    nfc_next          = nfc;
    prev_next         = prev;
    lfb_next          = lfb;
    emitted_next      = emitted;
    cur_next          = cur;
    code_in_next      = code_in;
    depth_next        = depth;
    len_next          = len;
    first_next        = first;
    restart_emit_next = restart_emit;
    done_r_next       = done_r;
    oob_next          = oob;
    pos_next          = pos;
    nchunk_next       = nchunk;
    iss_next          = iss;
    rd_addr_next      = rd_addr;
    rd_v_next         = 1'b0;
    rd_idx_next       = rd_idx;
    chunk_clear       = 1'b0;
    out_load          = 1'b0;
    out_marker        = 1'b0;
    out_vb_next       = nchunk;
    out_last_next     = 1'b0;
    out_done_next     = 1'b0;
    dict_re           = 1'b0;
    dict_we           = 1'b0;
    dict_raddr        = NFC_W'(cur) < NFC_W'(DICT_ENTRIES) ? DI_W'(cur) : '0;
    dict_waddr        = nfc[DI_W-1:0];
    stk_we            = 1'b0;
    stk_re            = 1'b0;
    stk_waddr         = depth[SI_W-1:0];
    stk_wdata         = cur[7:0];
    grow_lim          = (NFC_W'(1) << cw) - NFC_W'(2);
    sum               = 25'(emitted) + 25'(len);
    rem               = '0;
    pos_adv           = pos + LEN_W'(nchunk);

    case (state)
      S_IDLE: begin
        if (fire) begin
          if (start_stream) begin
            phase_next   = PH_SEED;
            cw_next      = CW_W'(WIDTH_START);
            nfc_next     = NFC_W'(FREE_INIT);
            prev_next    = '0;
            lfb_next     = '0;
            emitted_next = '0;
          end
          if (code_valid) begin
            code_in_next = code;
            case (ph_e)
              PH_SEED: begin
                prev_next  = code;
                lfb_next   = code[7:0];
                phase_next = PH_RUN;
              end
              PH_AFTER_RESTART: begin
                prev_next         = code;
                lfb_next          = code[7:0];
                stk_we            = 1'b1;
                stk_waddr         = '0;
                stk_wdata         = code[7:0];
                len_next          = LEN_W'(1);
                restart_emit_next = 1'b1;
                state_next        = S_ACCT;
              end
              default: begin
                // normal run; a fresh start cleared the count above
                if ((!start_stream && emitted >= limit) ||
                    NFC_W'(code) == NFC_W'(CODE_END)) begin
                  phase_next = PH_DONE;
                  state_next = S_MARK;
                end else if (NFC_W'(code) == NFC_W'(CODE_RESTART)) begin
                  nfc_next   = NFC_W'(FREE_RESTART);
                  cw_next    = CW_W'(WIDTH_START);
                  phase_next = PH_AFTER_RESTART;
                end else begin
                  restart_emit_next = 1'b0;
                  state_next        = S_WALK;
                  if (NFC_W'(code) >= (start_stream ? NFC_W'(FREE_INIT) : nfc)) begin
                    // code not yet defined: previous string plus its first byte
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = start_stream ? 8'd0 : lfb;
                    depth_next = LEN_W'(1);
                    cur_next   = start_stream ? '0 : prev;
                  end else begin
                    depth_next = '0;
                    cur_next   = code;
                  end
                end
              end
            endcase
          end
        end
      end

      S_WALK: begin
        if (cur > CODE_W'(255) && depth < LEN_W'(STRING_CAP - 1)) begin
          dict_re    = 1'b1;
          oob_next   = !(NFC_W'(cur) < NFC_W'(DICT_ENTRIES));
          state_next = S_WAIT;
        end else begin
          stk_we     = 1'b1;
          len_next   = depth + LEN_W'(1);
          first_next = cur[7:0];
          state_next = S_ACCT;
        end
      end

      S_WAIT: begin
        stk_we     = 1'b1;
        stk_wdata  = oob ? 8'd0 : sfx_q;
        depth_next = depth + LEN_W'(1);
        cur_next   = oob ? '0 : pfx_q;
        state_next = S_WALK;
      end

      S_ACCT: begin
        if (!restart_emit) begin
          if (nfc > grow_lim && (32'(cw) + 32'd1) < WIDTH_STOP) begin
            cw_next = cw + CW_W'(1);
          end
          if (nfc < NFC_W'(DICT_ENTRIES)) begin
            dict_we  = 1'b1;
            nfc_next = nfc + NFC_W'(1);
          end
          prev_next = code_in;
          lfb_next  = first;
        end
        emitted_next = (sum > 25'(COUNT_MAX)) ? COUNT_MAX : sum[23:0];
        done_r_next  = (emitted_next >= limit);
        phase_next   = done_r_next ? PH_DONE : PH_RUN;
        pos_next     = '0;
        nchunk_next  = (len > LEN_W'(CHUNK_BYTES)) ? 6'(CHUNK_BYTES) : 6'(len);
        rd_addr_next = len - LEN_W'(1);
        iss_next     = '0;
        chunk_clear  = 1'b1;
        state_next   = S_EMIT;
      end

      S_EMIT: begin
        stk_re       = 1'b1;
        rd_v_next    = 1'b1;
        rd_idx_next  = iss[4:0];
        rd_addr_next = rd_addr - LEN_W'(1);
        iss_next     = iss + 6'd1;
        if (iss == nchunk - 6'd1) begin
          state_next = S_DRAIN;
        end
      end

      S_DRAIN: begin
        state_next = S_PUSH;
      end

      S_PUSH: begin
        if (!out_valid || !out_stall) begin
          out_load      = 1'b1;
          out_last_next = (pos_adv == len);
          out_done_next = (pos_adv == len) && done_r;
          pos_next      = pos_adv;
          if (pos_adv == len) begin
            state_next = S_IDLE;
          end else begin
            rem          = len - pos_adv;
            nchunk_next  = (rem > LEN_W'(CHUNK_BYTES)) ? 6'(CHUNK_BYTES) : 6'(rem);
            rd_addr_next = len - LEN_W'(1) - pos_adv;
            iss_next     = '0;
            chunk_clear  = 1'b1;
            state_next   = S_EMIT;
          end
        end
      end

      S_MARK: begin
        if (!out_valid || !out_stall) begin
          out_load      = 1'b1;
          out_marker    = 1'b1;
          out_vb_next   = '0;
          out_last_next = 1'b1;
          out_done_next = 1'b1;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_SEED;
      cw           <= CW_W'(WIDTH_START);
      nfc          <= NFC_W'(FREE_INIT);
      prev         <= '0;
      lfb          <= '0;
      emitted      <= '0;
      limit        <= COUNT_MAX;
      rd_v         <= 1'b0;
      restart_emit <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      cw           <= cw_next;
      nfc          <= nfc_next;
      prev         <= prev_next;
      lfb          <= lfb_next;
      emitted      <= emitted_next;
      rd_v         <= rd_v_next;
      restart_emit <= restart_emit_next;
      done_r       <= done_r_next;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    code_in <= code_in_next;
    depth   <= depth_next;
    len     <= len_next;
    first   <= first_next;
    oob     <= oob_next;
    pos     <= pos_next;
    nchunk  <= nchunk_next;
    iss     <= iss_next;
    rd_addr <= rd_addr_next;
    rd_idx  <= rd_idx_next;
  end

  // chunk assembly from the stack read pipe
  always_ff @(posedge clk) begin
    if (chunk_clear) begin
      chunk <= '0;
    end else if (rd_v) begin
      chunk[rd_idx*8 +: 8] <= stk_q;
    end
  end

  // dictionary memories
  always_ff @(posedge clk) begin
    if (dict_we) begin
      pfx_mem[dict_waddr] <= prev;
      sfx_mem[dict_waddr] <= first;
    end
    if (dict_re) begin
      pfx_q <= pfx_mem[dict_raddr];
      sfx_q <= sfx_mem[dict_raddr];
    end
  end

  // string stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk_mem[rd_addr[SI_W-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chunk   <= out_marker ? '0 : chunk;
      valid_bytes <= out_vb_next;
      last_chunk  <= out_last_next;
      stream_done <= out_done_next;
    end
  end

  assign chunk_word_0 = out_chunk[63:0];
  assign chunk_word_1 = out_chunk[127:64];
  assign chunk_word_2 = out_chunk[191:128];
  assign chunk_word_3 = out_chunk[255:192];

  // a parked result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && out_valid && out_stall) |=> (state == S_PUSH))
    else $error("chunk push while output full");

  // a finished stream only appears on the last chunk
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_done) |-> last_chunk)
    else $error("stream_done without last_chunk");

  // the chain walk stays inside the stack
  a_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_WAIT) |-> (depth < LEN_W'(STRING_CAP)))
    else $error("walk depth beyond stack");

  // a data chunk carries 1 to 32 bytes
  a_vb: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !stream_done) |-> (valid_bytes != 6'd0 && valid_bytes <= 6'd32))
    else $error("bad chunk byte count");

endmodule

### hdl/lzwvd_unpack.sv
// lzwvd_unpack: lsb-first bit buffer that cuts variable-width codes from bytes
// depends on lzwvd_pkg
module lzwvd_unpack
  import lzwvd_pkg::*;
#(
  parameter int CODE_W = WIDTH_STOP_DEF - 1,
  parameter int CW_W   = $clog2(WIDTH_STOP_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              shift_en,
  input  logic [7:0]        data_byte,
  input  logic [CW_W-1:0]   code_width,
  output logic              code_valid,
  output logic [CODE_W-1:0] code
);

  localparam int BUF_W = CODE_W + 7;
  localparam int CNT_W = $clog2(BUF_W + 1);

  logic [BUF_W-1:0]  bits, bits_next, b0, b2;
  logic [CNT_W-1:0]  cnt, cnt_next, c0, c2;
  logic [CODE_W-1:0] mask;

  always_comb begin
    b0 = clear ? '0 : bits;
    c0 = clear ? '0 : cnt;
    b2 = b0 | (BUF_W'(data_byte) << c0);
    c2 = c0 + CNT_W'(8);
    for (int i = 0; i < CODE_W; i++) begin
      mask[i] = (i < 32'(code_width));
    end
    code       = b2[CODE_W-1:0] & mask;
    code_valid = 1'b0;
    bits_next  = b0;
    cnt_next   = c0;
    if (shift_en) begin
      if (c2 < CNT_W'(code_width)) begin
        bits_next = b2;
        cnt_next  = c2;
      end else begin
        code_valid = 1'b1;
        bits_next  = b2 >> code_width;
        cnt_next   = c2 - CNT_W'(code_width);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
      cnt  <= '0;
    end else begin
      bits <= bits_next;
      cnt  <= cnt_next;
    end
  end

endmodule

### tb/lzwvd_checker.sv
// lzwvd_checker: watches the item, chunk and config ports of the lzw decoder,
// predicts each chunk and compares; depends on lzwvd_pkg
`timescale 1ns / 100ps

module lzwvd_checker
  import lzwvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        start_stream,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] chunk_word_0,
  input  logic [63:0] chunk_word_1,
  input  logic [63:0] chunk_word_2,
  input  logic [63:0] chunk_word_3,
  input  logic [5:0]  valid_bytes,
  input  logic        last_chunk,
  input  logic        stream_done,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  localparam int DICT = 2048;
  localparam int STR_CAP = 2048;

  typedef struct {
    logic [63:0] w [4];
    logic [5:0]  nbytes;
    logic        last;
    logic        done;
  } chunk_t;

  chunk_t      chunk_q [$];
  logic [10:0] dict_prefix [DICT];
  logic [7:0]  dict_suffix [DICT];
  logic [7:0]  str_buf [STR_CAP];
  logic [31:0] bits;
  int          nbits;
  int          width;
  int          free_code;
  int          prev_code;
  logic [7:0]  prev_first;
  phase_t      phase;
  logic [23:0] emitted;
  logic [23:0] limit;

  assign pending = chunk_q.size();

  task automatic fresh_stream();
    bits = 0; nbits = 0; width = WIDTH_START; free_code = 257;
    prev_code = 0; prev_first = 0; phase = PH_SEED; emitted = 0;
  endtask

  // unwind a code into str_buf, reversed, starting at depth
  function automatic int unwind(int code, int depth);
    while (code > 255 && depth < STR_CAP - 1) begin
      str_buf[depth] = (code < DICT) ? dict_suffix[code] : 8'h00;
      depth++;
      code = (code < DICT) ? int'(dict_prefix[code]) : 0;
    end
    str_buf[depth] = code[7:0];
    return depth + 1;
  endfunction

  function automatic bit count_bytes(int n);
    int sum;
    sum = int'(emitted) + n;
    emitted = (sum > int'(COUNT_MAX)) ? COUNT_MAX : sum[23:0];
    return emitted >= limit;
  endfunction

  task automatic queue_string(int len, bit done);
    chunk_t c;
    int pos, n;
    pos = 0;
    while (pos < len) begin
      n = (len - pos > CHUNK_BYTES) ? CHUNK_BYTES : len - pos;
      for (int k = 0; k < 4; k++) c.w[k] = '0;
      for (int i = 0; i < n; i++)
        c.w[i / 8][(i % 8) * 8 +: 8] = str_buf[len - 1 - pos - i];
      c.nbytes = n[5:0];
      c.last = (pos + n == len);
      c.done = c.last && done;
      chunk_q.push_back(c);
      pos += n;
    end
  endtask

  task automatic decode_item(logic restart, logic [7:0] b);
    int code, len;
    logic [7:0] first;
    bit done;
    chunk_t mark;
    if (restart) fresh_stream();
    if (phase == PH_DONE) return;
    bits |= 32'(b) << nbits;
    nbits += 8;
    if (nbits < width) return;
    code = int'(bits & ((32'd1 << width) - 1));
    bits >>= width;
    nbits -= width;
    case (phase)
      PH_SEED: begin
        prev_code = code; prev_first = code[7:0]; phase = PH_RUN;
        return;
      end
      PH_AFTER_RESTART: begin
        prev_code = code; prev_first = code[7:0];
        str_buf[0] = prev_first;
        done = count_bytes(1);
        phase = done ? PH_DONE : PH_RUN;
        queue_string(1, done);
        return;
      end
      default: ;
    endcase
    // end code or limit already hit: a lone empty marker chunk
    if (emitted >= limit || code == int'(CODE_END)) begin
      for (int k = 0; k < 4; k++) mark.w[k] = '0;
      mark.nbytes = 0; mark.last = 1; mark.done = 1;
      chunk_q.push_back(mark);
      phase = PH_DONE;
      return;
    end
    if (code == int'(CODE_RESTART)) begin
      free_code = 258; width = WIDTH_START; phase = PH_AFTER_RESTART;
      return;
    end
    // code not yet in the table: previous string plus its own first byte
    if (code >= free_code) begin
      str_buf[0] = prev_first;
      len = unwind(prev_code, 1);
    end else begin
      len = unwind(code, 0);
    end
    first = str_buf[len - 1];
    if (free_code > (1 << width) - 2 && width + 1 < WIDTH_STOP_DEF) width++;
    if (free_code < DICT) begin
      dict_prefix[free_code] = prev_code[10:0];
      dict_suffix[free_code] = first;
      free_code++;
    end
    prev_code = code;
    prev_first = first;
    done = count_bytes(len);
    if (done) phase = PH_DONE;
    queue_string(len, done);
  endtask

  task automatic check_chunk();
    chunk_t e;
    bit bad;
    if (chunk_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected chunk: bytes %0d last %b done %b",
                                 valid_bytes, last_chunk, stream_done);
      return;
    end
    e = chunk_q.pop_front();
    bad = e.w[0] !== chunk_word_0 || e.w[1] !== chunk_word_1 ||
          e.w[2] !== chunk_word_2 || e.w[3] !== chunk_word_3 ||
          e.nbytes !== valid_bytes || e.last !== last_chunk || e.done !== stream_done;
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("chunk mismatch: exp bytes %0d last %b done %b, got %0d %b %b",
                 e.nbytes, e.last, e.done, valid_bytes, last_chunk, stream_done);
        $display("  exp %h %h %h %h", e.w[0], e.w[1], e.w[2], e.w[3]);
        $display("  got %h %h %h %h", chunk_word_0, chunk_word_1, chunk_word_2,
                 chunk_word_3);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fresh_stream();
      limit = COUNT_MAX;
      errors = 0;
      chunk_q.delete();
    end else begin
      if (out_valid && !out_stall) check_chunk();
      if (in_valid && !in_stall) decode_item(start_stream, data_byte);
      if (cfg_we) limit = cfg_wdata;
    end
  end

  final_check: assert property (@(posedge clk) 1);

endmodule

### tb/testbench.sv
// testbench: drives lzw code streams into lzw_variable_width_decoder and
// gives the verdict; depends on lzwvd_pkg and lzwvd_checker
`timescale 1ns / 100ps

module testbench;
  import lzwvd_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        start_stream;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] chunk_word_0, chunk_word_1, chunk_word_2, chunk_word_3;
  logic [5:0]  valid_bytes;
  logic        last_chunk;
  logic        stream_done;
  logic        cfg_we;
  logic [23:0] cfg_wdata;
  int          errors;
  int          pending;

  // stream builder state, a shadow of the decoder's width and free-code counter
  logic [31:0] pack_bits;
  int          pack_n;
  int          code_w;
  int          next_code;
  phase_t      gen_phase;
  bit          first_byte;
  int          burst_left;
  int          stall_mode;
  int          stall_timer;

  lzw_variable_width_decoder i_dut (
    .clk, .rst, .in_valid, .in_stall, .start_stream, .data_byte,
    .out_valid, .out_stall, .chunk_word_0, .chunk_word_1, .chunk_word_2,
    .chunk_word_3, .valid_bytes, .last_chunk, .stream_done, .cfg_we, .cfg_wdata
  );

  lzwvd_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .start_stream, .data_byte,
    .out_valid, .out_stall, .chunk_word_0, .chunk_word_1, .chunk_word_2,
    .chunk_word_3, .valid_bytes, .last_chunk, .stream_done, .cfg_we, .cfg_wdata,
    .errors, .pending
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // hard stop, well above the slowest legal run
  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

  // receiver stall: a random mode (none, light, heavy), held for a random time
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_timer <= $urandom_range(10, 80);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // one item; called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] b);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid = 1'b1;
    start_stream = first_byte;
    data_byte = b;
    first_byte = 0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic begin_stream();
    pack_bits = 0; pack_n = 0; code_w = WIDTH_START; next_code = 257;
    gen_phase = PH_SEED; first_byte = 1;
  endtask

  // pack a code lsb first and track what the decoder will do with it
  task automatic put_code(int code);
    pack_bits |= 32'(code) << pack_n;
    pack_n += code_w;
    while (pack_n >= 8) begin
      send_byte(pack_bits[7:0]);
      pack_bits >>= 8;
      pack_n -= 8;
    end
    case (gen_phase)
      PH_SEED, PH_AFTER_RESTART: gen_phase = PH_RUN;
      PH_RUN: begin
        if (code == int'(CODE_END)) begin
          gen_phase = PH_DONE;
        end else if (code == int'(CODE_RESTART)) begin
          next_code = 258; code_w = WIDTH_START; gen_phase = PH_AFTER_RESTART;
        end else begin
          if (next_code > (1 << code_w) - 2 && code_w + 1 < WIDTH_STOP_DEF) code_w++;
          if (next_code < DICT_ENTRIES_DEF) next_code++;
        end
      end
      default: ;
    endcase
  endtask

  // flush leftover bits as a padded byte, optionally after the end code
  task automatic close_stream(bit with_end);
    if (with_end && gen_phase == PH_RUN) put_code(CODE_END);
    if (pack_n > 0) send_byte(pack_bits[7:0]);
    pack_n = 0;
  endtask

  // seed and post-restart codes stay below 256 and run codes never pass the
  // next free code, so no unwritten entry is read
  function automatic int pick_code();
    int r, top, hi;
    if (gen_phase != PH_RUN) return $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    top = (1 << code_w) - 1;
    hi = (next_code < top) ? next_code : top;
    if (r < 3) return CODE_RESTART;
    if (r < 15) return hi;
    if (r < 22) return $urandom_range(0, hi);
    if (r < 60 && next_code > 258) return $urandom_range(258, next_code - 1);
    return $urandom_range(0, 255);
  endfunction

  // only while idle: everything drained plus settle time
  task automatic set_limit(logic [23:0] v);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_stream(int ncodes, bit with_end);
    begin_stream();
    for (int i = 0; i < ncodes; i++) put_code(pick_code());
    close_stream(with_end);
  endtask

  initial begin
    rst = 1; in_valid = 0; start_stream = 0; data_byte = 0;
    cfg_we = 0; cfg_wdata = 0; out_stall = 0; stall_mode = 0; stall_timer = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: defined code, code not yet defined, beyond next free, restart, end
    begin_stream();
    put_code(97); put_code(98); put_code(258); put_code(255); put_code(0);
    put_code(259); put_code(300); put_code(CODE_RESTART); put_code(200);
    put_code(258); put_code(CODE_RESTART); put_code(0); put_code(255);
    close_stream(1);
    // strings over two chunks: repeat the not-yet-defined code
    begin_stream();
    put_code(170);
    for (int i = 0; i < 40; i++) put_code(next_code);
    close_stream(1);

    // limit zero: first real code gives the marker, later bytes ignored
    set_limit(24'd0);
    begin_stream();
    put_code(5); put_code(6); put_code(7); put_code(8);
    close_stream(0);
    // limit one reached by the code after a restart
    set_limit(24'd1);
    begin_stream();
    put_code(9); put_code(CODE_RESTART); put_code(255); put_code(3);
    close_stream(0);
    set_limit(24'd40);
    random_stream(10, 0);

    // random: short streams with varied limits, some cut off by a new start
    set_limit(COUNT_MAX);
    for (int s = 0; s < 4; s++) begin
      if (s % 4 == 3) set_limit($urandom_range(1, 120));
      if (s % 4 == 0) set_limit(COUNT_MAX);
      random_stream($urandom_range(4, 12), $urandom_range(0, 2) != 0);
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

### lzw_variable_width_decoder.f
hdl/lzwvd_pkg.sv
hdl/lzwvd_unpack.sv
hdl/lzw_variable_width_decoder.sv
tb/lzwvd_checker.sv
tb/testbench.sv
